[sv/pdcq_pkg.sv]
// Shared types and constants of the PWM duty capture qualifier.
package pdcq_pkg;

   // Duty and counter widths
   localparam int DUTY_W  = 10;
   localparam int COUNT_W = 4;
   localparam int INDEX_W = 3;

   // Full scale duty, seen through the 10-bit duty field
   localparam int                FULL_SCALE      = 1000;
   localparam logic [DUTY_W-1:0] FULL_SCALE_DUTY = DUTY_W'(FULL_SCALE);
   localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

   // Register reset values
   localparam logic [DUTY_W-1:0]  RST_LOW_ENTER     = 10'd10;
   localparam logic [DUTY_W-1:0]  RST_LOW_EXIT      = 10'd20;
   localparam logic [DUTY_W-1:0]  RST_HIGH_ENTER    = 10'd990;
   localparam logic [DUTY_W-1:0]  RST_HIGH_EXIT     = 10'd980;
   localparam logic [COUNT_W-1:0] RST_ENTER_COUNT   = 4'd2;
   localparam logic [COUNT_W-1:0] RST_EXIT_COUNT    = 4'd4;
   localparam logic [COUNT_W-1:0] RST_TIMEOUT_LIMIT = 4'd2;
   localparam logic [COUNT_W-1:0] RST_LEVEL_CONFIRM = 4'd3;

   // Register indexes on the csr port
   typedef enum logic [INDEX_W-1:0] {
      CSR_LOW_ENTER     = 3'd0,
      CSR_LOW_EXIT      = 3'd1,
      CSR_HIGH_ENTER    = 3'd2,
      CSR_HIGH_EXIT     = 3'd3,
      CSR_ENTER_COUNT   = 3'd4,
      CSR_EXIT_COUNT    = 3'd5,
      CSR_TIMEOUT_LIMIT = 3'd6,
      CSR_LEVEL_CONFIRM = 3'd7
   } csr_index_type;

   // Endpoint lock zone
   typedef enum logic [1:0] {
      ZONE_NORMAL = 2'd0,
      ZONE_LOW    = 2'd1,
      ZONE_HIGH   = 2'd2
   } zone_type;

   // Configuration as seen by the qualifier
   typedef struct packed {
      logic [DUTY_W-1:0]  low_enter_level;
      logic [DUTY_W-1:0]  low_exit_level;
      logic [DUTY_W-1:0]  high_enter_level;
      logic [DUTY_W-1:0]  high_exit_level;
      logic [COUNT_W-1:0] enter_count;
      logic [COUNT_W-1:0] exit_count;
      logic [COUNT_W-1:0] timeout_limit;
      logic [COUNT_W-1:0] level_confirm_count;
   } cfg_type;

   // One input item
   typedef struct packed {
      logic              capture_ready;
      logic [DUTY_W-1:0] captured_duty;
      logic              pin_level;
      logic [DUTY_W-1:0] held_duty;
   } item_type;

   // One result item
   typedef struct packed {
      logic [DUTY_W-1:0] target_duty;
      zone_type          lock_zone;
   } result_type;

endpackage

[sv/pwm_duty_capture_qualifier.sv]
// PWM duty capture qualifier: top level with input and result registers.
//
// Usage: one item per tick enters on the req_ stream. req_tuser carries
// capture_ready; req_tdata carries captured_duty, pin_level and held_duty.
// For each item one result leaves on the rsp_ stream with the qualified
// target duty and the lock zone reached after that tick.
// Path: an accepted item waits in the input register, then is qualified
// and loaded into the result register, which drives rsp_tvalid.
// Throughput: one item per cycle while rsp_ is not stalled; the input register
// and the result register form a two-stage pipeline and the qualifier state
// (miss count, level run, zone and zone run) updates in one pass between them.
// Stall: when rsp_tready is low the result register holds; one more item
// waits in the input register, then req_tready drops until rsp_ drains.
// Reset: synchronous, clears both stages, the qualifier state (zone normal)
// and loads the register defaults. The csr_ channel writes a register each
// cycle csr_valid is high (csr_ready is always high); write only while idle.
module pwm_duty_capture_qualifier (
   input  logic                          clock,
   input  logic                          reset,
   // Input items
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // captured_duty[9:0], pin_level[10],
                                                     // held_duty[20:11], zero pad
   input  logic                          req_tuser,  // capture_ready
   // Result items
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,  // target_duty[9:0], lock_zone[11:10],
                                                     // zero pad
   // Configuration writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pdcq_pkg::INDEX_W-1:0]  csr_index,
   input  logic [pdcq_pkg::DUTY_W-1:0]   csr_data
);

   localparam int DW = pdcq_pkg::DUTY_W;

   pdcq_pkg::cfg_type    cfg;
   pdcq_pkg::item_type   item_ff, item_in;
   logic                 item_valid_ff;
   pdcq_pkg::result_type result;
   pdcq_pkg::result_type result_ff;
   logic                 rsp_valid_ff;
   logic                 advance;
   logic                 step;

   pdcq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Pipeline control
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = item_valid_ff && advance;
   assign req_tready = !item_valid_ff || advance;

   // Unpack the input item
   always_comb begin
      item_in.capture_ready = req_tuser;
      item_in.captured_duty = req_tdata[DW-1:0];
      item_in.pin_level     = req_tdata[DW];
      item_in.held_duty     = req_tdata[2*DW:DW+1];
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   pdcq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, result_ff.lock_zone, result_ff.target_duty};

endmodule

[sv/pdcq_csr.sv]
// Configuration register file of the PWM duty capture qualifier.
module pdcq_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pdcq_pkg::INDEX_W-1:0]  csr_index,
   input  logic [pdcq_pkg::DUTY_W-1:0]   csr_data,
   output pdcq_pkg::cfg_type             cfg
);

   pdcq_pkg::cfg_type cfg_ff;
   pdcq_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode a write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (pdcq_pkg::csr_index_type'(csr_index))
            pdcq_pkg::CSR_LOW_ENTER:     cfg_in.low_enter_level  = csr_data;
            pdcq_pkg::CSR_LOW_EXIT:      cfg_in.low_exit_level   = csr_data;
            pdcq_pkg::CSR_HIGH_ENTER:    cfg_in.high_enter_level = csr_data;
            pdcq_pkg::CSR_HIGH_EXIT:     cfg_in.high_exit_level  = csr_data;
            pdcq_pkg::CSR_ENTER_COUNT:
               cfg_in.enter_count = csr_data[pdcq_pkg::COUNT_W-1:0];
            pdcq_pkg::CSR_EXIT_COUNT:
               cfg_in.exit_count = csr_data[pdcq_pkg::COUNT_W-1:0];
            pdcq_pkg::CSR_TIMEOUT_LIMIT:
               cfg_in.timeout_limit = csr_data[pdcq_pkg::COUNT_W-1:0];
            pdcq_pkg::CSR_LEVEL_CONFIRM:
               cfg_in.level_confirm_count = csr_data[pdcq_pkg::COUNT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_enter_level     <= pdcq_pkg::RST_LOW_ENTER;
         cfg_ff.low_exit_level      <= pdcq_pkg::RST_LOW_EXIT;
         cfg_ff.high_enter_level    <= pdcq_pkg::RST_HIGH_ENTER;
         cfg_ff.high_exit_level     <= pdcq_pkg::RST_HIGH_EXIT;
         cfg_ff.enter_count         <= pdcq_pkg::RST_ENTER_COUNT;
         cfg_ff.exit_count          <= pdcq_pkg::RST_EXIT_COUNT;
         cfg_ff.timeout_limit       <= pdcq_pkg::RST_TIMEOUT_LIMIT;
         cfg_ff.level_confirm_count <= pdcq_pkg::RST_LEVEL_CONFIRM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/pdcq_core.sv]
// Timeout, level confirm and endpoint lock logic with its state registers.
module pdcq_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  pdcq_pkg::item_type     item,
   input  pdcq_pkg::cfg_type      cfg,
   output pdcq_pkg::result_type   result
);

   localparam int CW = pdcq_pkg::COUNT_W;
   localparam int DW = pdcq_pkg::DUTY_W;

   logic [CW-1:0]      miss_count_ff, miss_count_in;
   logic               candidate_level_ff, candidate_level_in;
   logic [CW-1:0]      level_run_ff, level_run_in;
   pdcq_pkg::zone_type zone_ff, zone_in;
   logic [CW-1:0]      zone_run_ff, zone_run_in;

   logic [CW:0]   miss_inc;
   logic          timed_out;
   logic [CW:0]   level_inc;
   logic          level_confirmed;
   logic [DW-1:0] cand;
   logic [CW-1:0] run_bump;
   logic          enter_done;
   logic          exit_done;
   logic [DW-1:0] duty_out;

   // Miss counter and pin level confirm
   always_comb begin
      miss_inc           = {1'b0, miss_count_ff} + 1'b1;
      timed_out          = miss_inc >= {1'b0, cfg.timeout_limit};
      level_inc          = {1'b0, level_run_ff} + 1'b1;
      level_confirmed    = 1'b0;
      miss_count_in      = miss_count_ff;
      candidate_level_in = candidate_level_ff;
      level_run_in       = level_run_ff;
      cand               = item.held_duty;
      if (item.capture_ready) begin
         miss_count_in = '0;
         cand          = item.captured_duty;
      end else if (timed_out) begin
         miss_count_in = cfg.timeout_limit;
         if (item.pin_level != candidate_level_ff) begin
            candidate_level_in = item.pin_level;
            level_run_in       = CW'(1);
         end else if (level_inc >= {1'b0, cfg.level_confirm_count}) begin
            level_run_in    = cfg.level_confirm_count;
            level_confirmed = 1'b1;
         end else begin
            level_run_in = level_inc[CW-1:0];
         end
         if (level_confirmed) begin
            cand = item.pin_level ? pdcq_pkg::FULL_SCALE_DUTY : '0;
         end
      end else begin
         miss_count_in = miss_inc[CW-1:0];
      end
   end

   // Endpoint lock: three zones with enter and exit run counts
   always_comb begin
      run_bump    = (zone_run_ff == pdcq_pkg::COUNT_MAX) ? zone_run_ff
                                                         : zone_run_ff + 1'b1;
      enter_done  = run_bump >= cfg.enter_count;
      exit_done   = run_bump >= cfg.exit_count;
      zone_in     = zone_ff;
      zone_run_in = zone_run_ff;
      duty_out    = cand;
      case (zone_ff)
         pdcq_pkg::ZONE_NORMAL: begin
            if (cand <= cfg.low_enter_level) begin
               zone_run_in = run_bump;
               if (enter_done) begin
                  zone_in     = pdcq_pkg::ZONE_LOW;
                  zone_run_in = '0;
                  duty_out    = '0;
               end
            end else if (cand >= cfg.high_enter_level) begin
               zone_run_in = run_bump;
               if (enter_done) begin
                  zone_in     = pdcq_pkg::ZONE_HIGH;
                  zone_run_in = '0;
                  duty_out    = pdcq_pkg::FULL_SCALE_DUTY;
               end else begin
                  duty_out = cfg.high_enter_level;
               end
            end else begin
               zone_run_in = '0;
            end
         end
         pdcq_pkg::ZONE_LOW: begin
            duty_out = '0;
            if (cand >= cfg.low_exit_level) begin
               zone_run_in = run_bump;
               if (exit_done) begin
                  zone_in     = pdcq_pkg::ZONE_NORMAL;
                  zone_run_in = '0;
                  duty_out    = cand;
               end
            end else begin
               zone_run_in = '0;
            end
         end
         pdcq_pkg::ZONE_HIGH: begin
            duty_out = pdcq_pkg::FULL_SCALE_DUTY;
            if (cand <= cfg.high_exit_level) begin
               zone_run_in = run_bump;
               if (exit_done) begin
                  zone_in     = pdcq_pkg::ZONE_NORMAL;
                  zone_run_in = '0;
                  duty_out    = cand;
               end
            end else begin
               zone_run_in = '0;
            end
         end
         default: begin
            duty_out = cand;
         end
      endcase
   end

   assign result.target_duty = duty_out;
   assign result.lock_zone   = zone_in;

   // State advances once per item that moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         miss_count_ff      <= '0;
         candidate_level_ff <= 1'b0;
         level_run_ff       <= '0;
         zone_ff            <= pdcq_pkg::ZONE_NORMAL;
         zone_run_ff        <= '0;
      end else if (step) begin
         miss_count_ff      <= miss_count_in;
         candidate_level_ff <= candidate_level_in;
         level_run_ff       <= level_run_in;
         zone_ff            <= zone_in;
         zone_run_ff        <= zone_run_in;
      end
   end

   // Locked zones force the endpoint duty
   a_low_lock_zero: assert property (@(posedge clock) disable iff (reset)
      step && zone_in == pdcq_pkg::ZONE_LOW |-> duty_out == '0)
      else $error("low lock result is not zero");

   a_high_lock_full: assert property (@(posedge clock) disable iff (reset)
      step && zone_in == pdcq_pkg::ZONE_HIGH |-> duty_out == pdcq_pkg::FULL_SCALE_DUTY)
      else $error("high lock result is not full scale");

   // Zone state only moves with an item
   a_zone_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(zone_ff) && $stable(zone_run_ff))
      else $error("zone state changed without an item");

   // A zone change restarts the run count
   a_zone_run_clear: assert property (@(posedge clock) disable iff (reset)
      step && zone_in != zone_ff |=> zone_run_ff == '0)
      else $error("run count not cleared on zone change");

   // A ready capture clears the miss counter
   a_miss_clear: assert property (@(posedge clock) disable iff (reset)
      step && item.capture_ready |=> miss_count_ff == '0)
      else $error("miss counter not cleared by capture");

endmodule
